// ===== sv/idr_pkg.sv =====
// ----------------------------------------------------------------------------
// idr_pkg
// Shared types, register codes and the step program of the dead reckoning
// sequencer.
// ----------------------------------------------------------------------------
package idr_pkg;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int NUM_STEPS  = 33;
    localparam int STEP_W     = 6;

    localparam logic [30:0] THRESH_RST  = 31'd3277;
    localparam logic [30:0] GRAVITY_RST = 31'd642253;
    localparam logic [23:0] PERIOD_RST  = 24'd83886;

    localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] vel_x;
        logic signed [63:0] vel_y;
        logic signed [63:0] vel_z;
        logic signed [63:0] pos_x;
        logic signed [63:0] pos_y;
        logic signed [63:0] pos_z;
        logic               at_rest;
    } t_out_item;

    typedef struct packed {
        logic [30:0] still_threshold;
        logic [30:0] gravity_level;
        logic [23:0] sample_period;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_stat;

    typedef enum logic [1:0] {
        REG_THRESH  = 2'd0,
        REG_GRAVITY = 2'd1,
        REG_PERIOD  = 2'd2
    } t_reg_idx;

    typedef enum logic [4:0] {
        A_Q0, A_Q1, A_Q2, A_Q3,
        A_T0, A_T1, A_T2, A_T3,
        A_A0, A_A1, A_A2,
        A_VHI0, A_VHI1, A_VHI2,
        A_VLO0, A_VLO1, A_VLO2
    } t_asel;

    typedef enum logic [2:0] {
        B_V1, B_V2, B_V3, B_Q0, B_Q1, B_Q2, B_Q3, B_DT
    } t_bsel;

    typedef enum logic [1:0] {
        K_ROT, K_VEL, K_POS
    } t_kind;

    // destination codes: rotation temporaries, world acceleration, axes
    localparam logic [2:0] D_T0 = 3'd0;
    localparam logic [2:0] D_T1 = 3'd1;
    localparam logic [2:0] D_T2 = 3'd2;
    localparam logic [2:0] D_T3 = 3'd3;
    localparam logic [2:0] D_A0 = 3'd4;
    localparam logic [2:0] D_A1 = 3'd5;
    localparam logic [2:0] D_A2 = 3'd6;
    localparam logic [2:0] D_X  = 3'd0;
    localparam logic [2:0] D_Y  = 3'd1;
    localparam logic [2:0] D_Z  = 3'd2;

    typedef struct packed {
        t_asel      a_sel;
        t_bsel      b_sel;
        t_kind      kind;
        logic [2:0] dest;
        logic       neg;
        logic       first;
        logic       last;
    } t_uop;

    function automatic t_uop mk_uop(input t_asel a, input t_bsel b, input t_kind k,
                                    input logic [2:0] d, input logic n,
                                    input logic f, input logic l);
        t_uop u;
        u.a_sel = a;
        u.b_sel = b;
        u.kind  = k;
        u.dest  = d;
        u.neg   = n;
        u.first = f;
        u.last  = l;
        return u;
    endfunction

    // one product per step, accumulated in the following cycle
    function automatic t_uop idr_uop(input logic [STEP_W-1:0] step);
        t_uop u;
        case (step)
            // t = q * (0, v)
            6'd0:  u = mk_uop(A_Q1, B_V1, K_ROT, D_T0, 1'b1, 1'b1, 1'b0);
            6'd1:  u = mk_uop(A_Q2, B_V2, K_ROT, D_T0, 1'b1, 1'b0, 1'b0);
            6'd2:  u = mk_uop(A_Q3, B_V3, K_ROT, D_T0, 1'b1, 1'b0, 1'b1);
            6'd3:  u = mk_uop(A_Q0, B_V1, K_ROT, D_T1, 1'b0, 1'b1, 1'b0);
            6'd4:  u = mk_uop(A_Q2, B_V3, K_ROT, D_T1, 1'b0, 1'b0, 1'b0);
            6'd5:  u = mk_uop(A_Q3, B_V2, K_ROT, D_T1, 1'b1, 1'b0, 1'b1);
            6'd6:  u = mk_uop(A_Q0, B_V2, K_ROT, D_T2, 1'b0, 1'b1, 1'b0);
            6'd7:  u = mk_uop(A_Q1, B_V3, K_ROT, D_T2, 1'b1, 1'b0, 1'b0);
            6'd8:  u = mk_uop(A_Q3, B_V1, K_ROT, D_T2, 1'b0, 1'b0, 1'b1);
            6'd9:  u = mk_uop(A_Q0, B_V3, K_ROT, D_T3, 1'b0, 1'b1, 1'b0);
            6'd10: u = mk_uop(A_Q1, B_V2, K_ROT, D_T3, 1'b0, 1'b0, 1'b0);
            6'd11: u = mk_uop(A_Q2, B_V1, K_ROT, D_T3, 1'b1, 1'b0, 1'b1);
            // r = t * conj(q)
            6'd12: u = mk_uop(A_T0, B_Q1, K_ROT, D_A0, 1'b1, 1'b1, 1'b0);
            6'd13: u = mk_uop(A_T1, B_Q0, K_ROT, D_A0, 1'b0, 1'b0, 1'b0);
            6'd14: u = mk_uop(A_T2, B_Q3, K_ROT, D_A0, 1'b1, 1'b0, 1'b0);
            6'd15: u = mk_uop(A_T3, B_Q2, K_ROT, D_A0, 1'b0, 1'b0, 1'b1);
            6'd16: u = mk_uop(A_T0, B_Q2, K_ROT, D_A1, 1'b1, 1'b1, 1'b0);
            6'd17: u = mk_uop(A_T1, B_Q3, K_ROT, D_A1, 1'b0, 1'b0, 1'b0);
            6'd18: u = mk_uop(A_T2, B_Q0, K_ROT, D_A1, 1'b0, 1'b0, 1'b0);
            6'd19: u = mk_uop(A_T3, B_Q1, K_ROT, D_A1, 1'b1, 1'b0, 1'b1);
            6'd20: u = mk_uop(A_T0, B_Q3, K_ROT, D_A2, 1'b1, 1'b1, 1'b0);
            6'd21: u = mk_uop(A_T1, B_Q2, K_ROT, D_A2, 1'b1, 1'b0, 1'b0);
            6'd22: u = mk_uop(A_T2, B_Q1, K_ROT, D_A2, 1'b0, 1'b0, 1'b0);
            6'd23: u = mk_uop(A_T3, B_Q0, K_ROT, D_A2, 1'b0, 1'b0, 1'b1);
            // velocity
            6'd24: u = mk_uop(A_A0, B_DT, K_VEL, D_X, 1'b0, 1'b1, 1'b1);
            6'd25: u = mk_uop(A_A1, B_DT, K_VEL, D_Y, 1'b0, 1'b1, 1'b1);
            6'd26: u = mk_uop(A_A2, B_DT, K_VEL, D_Z, 1'b0, 1'b1, 1'b1);
            // position, high word then low word of velocity
            6'd27: u = mk_uop(A_VHI0, B_DT, K_POS, D_X, 1'b0, 1'b1, 1'b0);
            6'd28: u = mk_uop(A_VLO0, B_DT, K_POS, D_X, 1'b0, 1'b0, 1'b1);
            6'd29: u = mk_uop(A_VHI1, B_DT, K_POS, D_Y, 1'b0, 1'b1, 1'b0);
            6'd30: u = mk_uop(A_VLO1, B_DT, K_POS, D_Y, 1'b0, 1'b0, 1'b1);
            6'd31: u = mk_uop(A_VHI2, B_DT, K_POS, D_Z, 1'b0, 1'b1, 1'b0);
            6'd32: u = mk_uop(A_VLO2, B_DT, K_POS, D_Z, 1'b0, 1'b0, 1'b1);
            default: u = mk_uop(A_Q0, B_V1, K_ROT, D_T0, 1'b0, 1'b0, 1'b0);
        endcase
        return u;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > S32_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < S32_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = signed'(x[31:0]);
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [63:0] r;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            r = s[64] ? S64_MIN : S64_MAX;
        end else begin
            r = signed'(s[63:0]);
        end
        return r;
    endfunction

endpackage

// ===== sv/idr_cfg.sv =====
// ----------------------------------------------------------------------------
// idr_cfg
// APB register file: rest threshold, gravity level and sample period.
// ----------------------------------------------------------------------------
module idr_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [idr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [idr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [idr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output idr_pkg::t_cfg                  o_cfg
);
    import idr_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.still_threshold <= THRESH_RST;
            r_cfg.gravity_level   <= GRAVITY_RST;
            r_cfg.sample_period   <= PERIOD_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_THRESH:  r_cfg.still_threshold <= pwdata[30:0];
                REG_GRAVITY: r_cfg.gravity_level   <= pwdata[30:0];
                REG_PERIOD:  r_cfg.sample_period   <= pwdata[23:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_THRESH:  prdata = {1'b0, r_cfg.still_threshold};
            REG_GRAVITY: prdata = {1'b0, r_cfg.gravity_level};
            REG_PERIOD:  prdata = {8'd0, r_cfg.sample_period};
            default:     prdata = '0;
        endcase
    end

endmodule

// ===== sv/idr_mul.sv =====
// ----------------------------------------------------------------------------
// idr_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module idr_mul (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [idr_pkg::MUL_W-1:0]  i_a,
    input  logic signed [idr_pkg::MUL_W-1:0]  i_b,
    output logic signed [idr_pkg::PROD_W-1:0] o_prod
);
    import idr_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    assign o_prod = r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

endmodule

// ===== sv/idr_core.sv =====
// ----------------------------------------------------------------------------
// idr_core
// Step sequencer, operand selection, accumulator and navigation state.
// ----------------------------------------------------------------------------
module idr_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  idr_pkg::t_in_item    i_in,
    input  idr_pkg::t_cfg        i_cfg,
    input  logic                 i_out_free,
    output idr_pkg::t_core_stat  o_stat,
    output idr_pkg::t_out_item   o_result
);
    import idr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_FLUSH = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

    t_state r_state, n_state;
    logic [STEP_W-1:0] r_step;
    t_in_item r_in;
    logic r_rest;
    logic r_pv;
    t_uop r_puop;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_t [4];
    logic signed [31:0] r_a [3];
    logic signed [63:0] r_vel [3];
    logic signed [63:0] r_pos [3];

    t_uop w_uop;
    logic w_issue;
    logic signed [MUL_W-1:0] w_opa, w_opb;
    logic signed [PROD_W-1:0] w_prod;
    logic w_rest;
    logic [1:0] w_ax;

    logic signed [PROD_W-1:0] w_rsh, w_vsh, w_lsh;
    logic signed [63:0] w_rq, w_term, w_base, w_sum, w_gsum, w_inc, w_lowp, w_psum;
    logic signed [31:0] w_sat;

    function automatic logic [31:0] abs_u32(input logic signed [31:0] x);
        logic [31:0] r;
        r = x[31] ? 32'(-x) : 32'(x);
        return r;
    endfunction

    // strict compare on full magnitude, so a zero threshold never rests
    assign w_rest = (abs_u32(i_in.rate_x) < {1'b0, i_cfg.still_threshold})
                 && (abs_u32(i_in.rate_y) < {1'b0, i_cfg.still_threshold})
                 && (abs_u32(i_in.rate_z) < {1'b0, i_cfg.still_threshold});

    assign w_uop   = idr_uop(r_step);
    assign w_issue = (r_state == S_RUN);

    always_comb begin
        case (w_uop.a_sel)
            A_Q0:    w_opa = {r_in.quat_w[31], r_in.quat_w};
            A_Q1:    w_opa = {r_in.quat_x[31], r_in.quat_x};
            A_Q2:    w_opa = {r_in.quat_y[31], r_in.quat_y};
            A_Q3:    w_opa = {r_in.quat_z[31], r_in.quat_z};
            A_T0:    w_opa = {r_t[0][31], r_t[0]};
            A_T1:    w_opa = {r_t[1][31], r_t[1]};
            A_T2:    w_opa = {r_t[2][31], r_t[2]};
            A_T3:    w_opa = {r_t[3][31], r_t[3]};
            A_A0:    w_opa = {r_a[0][31], r_a[0]};
            A_A1:    w_opa = {r_a[1][31], r_a[1]};
            A_A2:    w_opa = {r_a[2][31], r_a[2]};
            A_VHI0:  w_opa = {r_vel[0][63], r_vel[0][63:32]};
            A_VHI1:  w_opa = {r_vel[1][63], r_vel[1][63:32]};
            A_VHI2:  w_opa = {r_vel[2][63], r_vel[2][63:32]};
            A_VLO0:  w_opa = {1'b0, r_vel[0][31:0]};
            A_VLO1:  w_opa = {1'b0, r_vel[1][31:0]};
            A_VLO2:  w_opa = {1'b0, r_vel[2][31:0]};
            default: w_opa = '0;
        endcase
    end

    always_comb begin
        case (w_uop.b_sel)
            B_V1:    w_opb = {r_in.accel_x[31], r_in.accel_x};
            B_V2:    w_opb = {r_in.accel_y[31], r_in.accel_y};
            B_V3:    w_opb = {r_in.accel_z[31], r_in.accel_z};
            B_Q0:    w_opb = {r_in.quat_w[31], r_in.quat_w};
            B_Q1:    w_opb = {r_in.quat_x[31], r_in.quat_x};
            B_Q2:    w_opb = {r_in.quat_y[31], r_in.quat_y};
            B_Q3:    w_opb = {r_in.quat_z[31], r_in.quat_z};
            B_DT:    w_opb = {9'd0, i_cfg.sample_period};
            default: w_opb = '0;
        endcase
    end

    idr_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_issue),
        .i_a    (w_opa),
        .i_b    (w_opb),
        .o_prod (w_prod)
    );

    // accumulate path, working in the cycle after the issue
    assign w_ax   = r_puop.dest[1:0];
    assign w_rsh  = (w_prod + PROD_W'(64'sd536870912)) >>> 30;
    assign w_rq   = signed'(w_rsh[63:0]);
    assign w_term = r_puop.neg ? -w_rq : w_rq;
    assign w_base = r_puop.first ? 64'sd0 : r_acc;
    assign w_sum  = w_base + w_term;
    assign w_gsum = (r_puop.dest == D_A2) ? w_sum - signed'({33'd0, i_cfg.gravity_level})
                                          : w_sum;
    assign w_sat  = sat32(w_gsum);
    assign w_vsh  = (w_prod + PROD_W'(64'sd128)) >>> 8;
    assign w_inc  = signed'(w_vsh[63:0]);
    // low word product is non-negative, and the shift rounds it to nearest
    assign w_lsh  = (w_prod + PROD_W'(64'sd8388608)) >>> 24;
    assign w_lowp = signed'(w_lsh[63:0]);
    assign w_psum = r_acc + w_lowp;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_start) n_state = S_RUN;
            S_RUN:   if (r_step == LAST_STEP) n_state = S_FLUSH;
            S_FLUSH: n_state = S_DONE;
            S_DONE:  if (i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_pv    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_vel[i] <= '0;
                r_pos[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_pv    <= w_issue;
            if (r_state == S_IDLE) begin
                r_step <= '0;
            end else if (w_issue) begin
                r_step <= r_step + 1'b1;
            end
            if (r_pv) begin
                case (r_puop.kind)
                    K_VEL: begin
                        r_vel[w_ax] <= r_rest ? 64'sd0 : sat_add64(r_vel[w_ax], w_inc);
                    end
                    K_POS: begin
                        if (r_puop.last) begin
                            r_pos[w_ax] <= sat_add64(r_pos[w_ax], w_psum);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_in   <= i_in;
            r_rest <= w_rest;
        end
        if (w_issue) begin
            r_puop <= w_uop;
        end
        if (r_pv) begin
            case (r_puop.kind)
                K_ROT: begin
                    r_acc <= w_sum;
                    if (r_puop.last) begin
                        if (r_puop.dest[2]) begin
                            r_a[r_puop.dest[1:0]] <= w_sat;
                        end else begin
                            r_t[r_puop.dest[1:0]] <= w_sat;
                        end
                    end
                end
                K_POS: begin
                    // high word times dt, scaled back to 32 fraction bits
                    if (r_puop.first) begin
                        r_acc <= signed'({w_prod[55:0], 8'd0});
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.done = (r_state == S_DONE) && i_out_free;

    assign o_result.vel_x   = r_vel[0];
    assign o_result.vel_y   = r_vel[1];
    assign o_result.vel_z   = r_vel[2];
    assign o_result.pos_x   = r_pos[0];
    assign o_result.pos_y   = r_pos[1];
    assign o_result.pos_z   = r_pos[2];
    assign o_result.at_rest = r_rest;

endmodule

// ===== sv/inertial_dead_reckoning_zupt.sv =====
// ----------------------------------------------------------------------------
// inertial_dead_reckoning_zupt
// Strapdown position integration with zero-velocity update, fixed point.
// ----------------------------------------------------------------------------
// One IMU sample is taken per request; the block then stalls its input while
// a single 33x33 multiplier works through 33 products under a step counter
// (12 for q*v, 12 for the conjugate product, 3 for velocity, 6 for position)
// with the accumulate in the cycle after each product. After the last product
// the core passes through a flush state to a done state, hands the result to
// the output register and goes idle, and only then is the next sample taken.
// The result waits in its own register, so the next sample is accepted while
// it is still pending; the core holds its finished result only when the
// output register is still full.
module inertial_dead_reckoning_zupt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  idr_pkg::t_in_item              i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output idr_pkg::t_out_item             o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [idr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [idr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [idr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import idr_pkg::*;

    t_cfg       w_cfg;
    t_core_stat w_stat;
    t_out_item  w_result;
    t_out_item  r_out;
    logic       r_out_valid;
    logic       w_out_free;
    logic       w_start;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_start     = i_in_valid && !w_stat.busy;
    assign o_in_stall  = w_stat.busy;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    idr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    idr_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_in       (i_in),
        .i_cfg      (w_cfg),
        .i_out_free (w_out_free),
        .o_stat     (w_stat),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stat.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.done) begin
            r_out <= w_result;
        end
    end

    // an accepted request starts the sequencer at once
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after a request was accepted");

    // the core never hands over while a pending result is stuck
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> (!o_out_valid || !i_out_stall))
        else $error("result handed over into a full output register");

    a_rest_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.at_rest |->
            (o_out.vel_x == 64'sd0) && (o_out.vel_y == 64'sd0) && (o_out.vel_z == 64'sd0))
        else $error("rest result with nonzero velocity");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_stat.done))
        else $error("output valid rose without a finished request");

endmodule

// ===== bench/idr_checker.sv =====
// ----------------------------------------------------------------------------
// idr_checker
// Watches the sample, result and register ports of the dead reckoning block,
// predicts every navigation result from the accepted samples and compares
// the results field by field, in order, and checks the register read data.
// ----------------------------------------------------------------------------
module idr_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  idr_pkg::t_in_item              i_in,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  idr_pkg::t_out_item             i_out,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [idr_pkg::CFG_ADDR_W-1:0] i_paddr,
    input  logic [idr_pkg::CFG_DATA_W-1:0] i_pwdata,
    input  logic [idr_pkg::CFG_DATA_W-1:0] i_prdata,
    input  logic                           i_pready,
    output int                             o_mismatches,
    output int                             o_results,
    output int                             o_rest_results,
    output int                             o_backlog
);
    import idr_pkg::*;

    localparam logic [30:0] INIT_THRESH  = 31'd3277;
    localparam logic [30:0] INIT_GRAVITY = 31'd642253;
    localparam logic [23:0] INIT_PERIOD  = 24'd83886;

    logic [30:0]        thresh_q;
    logic [30:0]        gravity_q;
    logic [23:0]        period_q;
    logic signed [63:0] vel_st [3];
    logic signed [63:0] pos_st [3];
    t_out_item          expected_nav [$];
    t_out_item          want;

    function automatic logic signed [63:0] wide32(input logic signed [31:0] x);
        return 64'(x);
    endfunction

    // q1.30 times q15.16, rounded back to 16 fraction bits
    function automatic logic signed [63:0] rnd_q30(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b + 64'sd536870912;
        return p >>> 30;
    endfunction

    function automatic logic signed [63:0] clip32(input logic signed [63:0] x);
        logic signed [63:0] r;
        if (x > 64'sd2147483647) begin
            r = 64'sd2147483647;
        end else if (x < -64'sd2147483648) begin
            r = -64'sd2147483648;
        end else begin
            r = x;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] add_clip64(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [63:0] r;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
            r = 64'sh7FFF_FFFF_FFFF_FFFF;
        end else if (s < -65'sh0_8000_0000_0000_0000) begin
            r = 64'sh8000_0000_0000_0000;
        end else begin
            r = s[63:0];
        end
        return r;
    endfunction

    // advances the velocity and position state by one sample
    function automatic t_out_item predict_nav_step(input t_in_item s);
        logic signed [31:0] rate [3];
        logic signed [32:0] mag;
        logic               still;
        logic signed [63:0] v1, v2, v3, q0, q1, q2, q3;
        logic signed [63:0] t0, t1, t2, t3;
        logic signed [63:0] acc [3];
        logic signed [63:0] dts;
        logic signed [95:0] vw, dw, pw;
        t_out_item          r;
        rate[0] = s.rate_x;
        rate[1] = s.rate_y;
        rate[2] = s.rate_z;
        still = 1'b1;
        for (int k = 0; k < 3; k++) begin
            mag = 33'(rate[k]);
            if (mag < 0) begin
                mag = -mag;
            end
            if (!($unsigned(mag) < {2'b00, thresh_q})) begin
                still = 1'b0;
            end
        end
        v1 = wide32(s.accel_x);
        v2 = wide32(s.accel_y);
        v3 = wide32(s.accel_z);
        q0 = wide32(s.quat_w);
        q1 = wide32(s.quat_x);
        q2 = wide32(s.quat_y);
        q3 = wide32(s.quat_z);

        t0 = clip32(-rnd_q30(q1, v1) - rnd_q30(q2, v2) - rnd_q30(q3, v3));
        t1 = clip32(rnd_q30(q0, v1) + rnd_q30(q2, v3) - rnd_q30(q3, v2));
        t2 = clip32(rnd_q30(q0, v2) - rnd_q30(q1, v3) + rnd_q30(q3, v1));
        t3 = clip32(rnd_q30(q0, v3) + rnd_q30(q1, v2) - rnd_q30(q2, v1));

        acc[0] = clip32(-rnd_q30(t0, q1) + rnd_q30(t1, q0) - rnd_q30(t2, q3)
                        + rnd_q30(t3, q2));
        acc[1] = clip32(-rnd_q30(t0, q2) + rnd_q30(t1, q3) + rnd_q30(t2, q0)
                        - rnd_q30(t3, q1));
        acc[2] = clip32(-rnd_q30(t0, q3) - rnd_q30(t1, q2) + rnd_q30(t2, q1)
                        + rnd_q30(t3, q0) - $signed({33'd0, gravity_q}));

        dts = $signed({40'd0, period_q});
        dw  = 96'(dts);
        for (int k = 0; k < 3; k++) begin
            if (still) begin
                vel_st[k] = 64'sd0;
            end else begin
                vel_st[k] = add_clip64(vel_st[k], (acc[k] * dts + 64'sd128) >>> 8);
            end
            // exact 56 fraction bit product, rounded to 32
            vw = 96'(vel_st[k]);
            pw = (vw * dw + 96'sd8388608) >>> 24;
            pos_st[k] = add_clip64(pos_st[k], pw[63:0]);
        end

        r.vel_x   = vel_st[0];
        r.vel_y   = vel_st[1];
        r.vel_z   = vel_st[2];
        r.pos_x   = pos_st[0];
        r.pos_y   = pos_st[1];
        r.pos_z   = pos_st[2];
        r.at_rest = still;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            o_mismatches++;
            if (o_mismatches <= 10) begin
                $display("mismatch on %s at result %0d: expected %h, got %h",
                         name, o_results, exp_v, got_v);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thresh_q  = INIT_THRESH;
            gravity_q = INIT_GRAVITY;
            period_q  = INIT_PERIOD;
            for (int k = 0; k < 3; k++) begin
                vel_st[k] = 64'sd0;
                pos_st[k] = 64'sd0;
            end
            expected_nav.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_nav.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10) begin
                        $display("result %0d arrived with no sample outstanding", o_results);
                    end
                end else begin
                    want = expected_nav.pop_front();
                    check_field("vel_x", want.vel_x, i_out.vel_x);
                    check_field("vel_y", want.vel_y, i_out.vel_y);
                    check_field("vel_z", want.vel_z, i_out.vel_z);
                    check_field("pos_x", want.pos_x, i_out.pos_x);
                    check_field("pos_y", want.pos_y, i_out.pos_y);
                    check_field("pos_z", want.pos_z, i_out.pos_z);
                    check_field("at_rest", {63'd0, want.at_rest}, {63'd0, i_out.at_rest});
                end
                if (i_out.at_rest) begin
                    o_rest_results++;
                end
                o_results++;
            end

            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (i_paddr[CFG_ADDR_W-1:2])
                        REG_THRESH:  thresh_q  = i_pwdata[30:0];
                        REG_GRAVITY: gravity_q = i_pwdata[30:0];
                        REG_PERIOD:  period_q  = i_pwdata[23:0];
                        default: ;
                    endcase
                end else begin
                    case (i_paddr[CFG_ADDR_W-1:2])
                        REG_THRESH:
                            check_field("still_threshold read", {33'd0, thresh_q},
                                        {32'd0, i_prdata});
                        REG_GRAVITY:
                            check_field("gravity_level read", {33'd0, gravity_q},
                                        {32'd0, i_prdata});
                        REG_PERIOD:
                            check_field("sample_period read", {40'd0, period_q},
                                        {32'd0, i_prdata});
                        default: ;
                    endcase
                end
            end

            if (i_in_valid && !i_in_stall) begin
                expected_nav.push_back(predict_nav_step(i_in));
            end
        end
        o_backlog = expected_nav.size();
    end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives IMU samples and register settings into the dead reckoning block with
// random gaps and output stalls, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module testbench;
    import idr_pkg::*;

    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          LONG_HOLD      = 400;
    localparam logic [30:0] DEF_THRESH     = 31'd3277;
    localparam logic [30:0] DEF_GRAVITY    = 31'd642253;
    localparam logic [23:0] DEF_PERIOD     = 24'd83886;

    localparam logic [CFG_ADDR_W-1:0] ADDR_THRESH   = {REG_THRESH, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_GRAVITY  = {REG_GRAVITY, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_PERIOD   = {REG_PERIOD, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = 4'd12;

    localparam logic signed [31:0] S_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic signed [31:0] HALF_RT = 32'sd759250125;   // cos 45 deg, q1.30
    localparam logic signed [31:0] G_Q16   = 32'sd642253;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr       = '0;
    logic [CFG_DATA_W-1:0] pwdata      = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int          n_sent     = 0;
    int          n_settings = 0;
    int          quiet      = 0;
    logic [30:0] cur_thresh = DEF_THRESH;
    int          mismatches, results, rest_results, backlog;

    always #6 i_clk = ~i_clk;

    inertial_dead_reckoning_zupt i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    idr_checker i_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in           (i_in),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out          (o_out),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .i_pready       (pready),
        .o_mismatches   (mismatches),
        .o_results      (results),
        .o_rest_results (rest_results),
        .o_backlog      (backlog)
    );

    function automatic t_in_item pack_sample(
        input logic signed [31:0] rx, input logic signed [31:0] ry,
        input logic signed [31:0] rz, input logic signed [31:0] ax,
        input logic signed [31:0] ay, input logic signed [31:0] az,
        input logic signed [31:0] qw, input logic signed [31:0] qx,
        input logic signed [31:0] qy, input logic signed [31:0] qz);
        t_in_item s;
        s.rate_x  = rx;
        s.rate_y  = ry;
        s.rate_z  = rz;
        s.accel_x = ax;
        s.accel_y = ay;
        s.accel_z = az;
        s.quat_w  = qw;
        s.quat_x  = qx;
        s.quat_y  = qy;
        s.quat_z  = qz;
        return s;
    endfunction

    function automatic int spread(input int span);
        int u;
        u = $urandom_range(0, 2 * span);
        return u - span;
    endfunction

    // mostly plausible motion, some rest, some threshold edges, some noise
    function automatic t_in_item random_sample(input logic [30:0] thr);
        t_in_item s;
        int       pick, span, thr_i, edge_v;
        pick  = $urandom_range(0, 99);
        thr_i = int'(thr);
        if (thr <= 31'd1) begin
            span = 0;
        end else if (thr > 31'h2000_0000) begin
            span = 32'h2000_0000;
        end else begin
            span = thr_i - 1;
        end
        s.rate_x  = spread(32'h0020_0000);
        s.rate_y  = spread(32'h0020_0000);
        s.rate_z  = spread(32'h0020_0000);
        s.accel_x = spread(32'h0020_0000);
        s.accel_y = spread(32'h0020_0000);
        s.accel_z = spread(32'h0020_0000) + (($urandom_range(0, 1) == 1) ? G_Q16 : 0);
        if ($urandom_range(0, 1) == 1) begin
            s.quat_w = ONE_Q30;
            s.quat_x = '0;
            s.quat_y = '0;
            s.quat_z = '0;
        end else begin
            s.quat_w = spread(32'h2000_0000);
            s.quat_x = spread(32'h2000_0000);
            s.quat_y = spread(32'h2000_0000);
            s.quat_z = spread(32'h2000_0000);
        end
        if (pick < 15) begin
            s = {$urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom};
        end else if (pick < 45) begin
            s.rate_x = spread(span);
            s.rate_y = spread(span);
            s.rate_z = spread(span);
            if (pick >= 35) begin
                case ($urandom_range(0, 5))
                    0:       edge_v = thr_i;
                    1:       edge_v = thr_i - 1;
                    2:       edge_v = -thr_i;
                    3:       edge_v = 1 - thr_i;
                    4:       edge_v = S_MIN;
                    default: edge_v = S_MAX;
                endcase
                case ($urandom_range(0, 2))
                    0:       s.rate_x = edge_v;
                    1:       s.rate_y = edge_v;
                    default: s.rate_z = edge_v;
                endcase
            end
        end
        return s;
    endfunction

    task automatic send_sample(input t_in_item s);
        int gap;
        gap = ((n_sent % 64) < 12) ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in       <= s;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
    endtask

    task automatic cfg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_all();
        cfg_access(1'b0, ADDR_THRESH, '0);
        cfg_access(1'b0, ADDR_GRAVITY, '0);
        cfg_access(1'b0, ADDR_PERIOD, '0);
    endtask

    task automatic set_config(input logic [31:0] thr, input logic [31:0] grav,
                              input logic [31:0] per);
        cfg_access(1'b1, ADDR_THRESH, thr);
        cfg_access(1'b1, ADDR_GRAVITY, grav);
        cfg_access(1'b1, ADDR_PERIOD, per);
        cur_thresh = thr[30:0];
        n_settings++;
        read_all();
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (results != n_sent) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        for (int k = 0; k < count; k++) begin
            send_sample(random_sample(cur_thresh));
        end
    endtask

    // result side: random stalls, calm stretches, and two long hold-offs
    initial begin
        int gap;
        int n_taken;
        n_taken = 0;
        forever begin
            if (n_taken == 60 || n_taken == 450) begin
                gap = LONG_HOLD;
            end else if ((n_taken % 80) < 15) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 12);
            end
            if (gap != 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            n_taken++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (psel && penable)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("no request moved for %0d cycles", WATCHDOG_LIMIT);
                $display("** inertial_dead_reckoning_zupt: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values, directed samples
        send_sample(pack_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_sample(pack_sample(32'sh0010_0000, -32'sh0010_0000, 32'sh0008_0000,
                                0, 0, G_Q16, ONE_Q30, 0, 0, 0));
        send_sample(pack_sample(32'sh0010_0000, 0, 0, 32'sh0001_0000, -32'sh0001_0000,
                                G_Q16 + 32'sh0001_0000, ONE_Q30, 0, 0, 0));
        send_sample(pack_sample(S_MIN, 0, 0, 32'sh0002_0000, 0, 0, ONE_Q30, 0, 0, 0));
        send_sample(pack_sample(3276, -3276, 3276, 32'sh0003_0000, 0, 0,
                                ONE_Q30, 0, 0, 0));
        send_sample(pack_sample(3277, 0, 0, 32'sh0001_0000, 0, G_Q16, ONE_Q30, 0, 0, 0));
        send_sample(pack_sample(0, -3277, 0, 0, 32'sh0001_0000, 0, ONE_Q30, 0, 0, 0));
        send_sample(pack_sample(0, 0, -3276, 32'sh0001_0000, 0, 0, ONE_Q30, 0, 0, 0));
        send_sample(pack_sample(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
                                ONE_Q30, 0, 0, 0));
        send_sample(pack_sample(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN,
                                ONE_Q30, 0, 0, 0));
        send_sample(pack_sample(32'sh0010_0000, 0, 0, S_MAX, S_MAX, S_MAX,
                                S_MAX, S_MAX, S_MAX, S_MAX));
        send_sample(pack_sample(32'sh0010_0000, 0, 0, S_MIN, S_MAX, S_MIN,
                                S_MIN, S_MIN, S_MIN, S_MIN));
        send_sample(pack_sample(0, 32'sh0010_0000, 0, S_MAX, S_MIN, S_MAX,
                                S_MIN, S_MAX, S_MIN, S_MAX));
        send_sample(pack_sample(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
                                S_MAX, S_MAX, S_MAX, S_MAX));
        send_sample(pack_sample(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN,
                                S_MIN, S_MIN, S_MIN, S_MIN));
        send_sample(pack_sample(0, 0, 32'sh0004_0000, 32'sh0001_0000, 0, G_Q16,
                                HALF_RT, 0, 0, HALF_RT));
        send_sample(pack_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_sample(random_sample(cur_thresh));
        send_sample(pack_sample(100, -100, 0, 32'sh0001_0000, 0, 0, ONE_Q30, 0, 0, 0));
        wait_drain();

        // zero threshold never rests, gravity at full scale, period masked to zero
        set_config(32'h0000_0000, 32'hFFFF_FFFF, 32'h0100_0000);
        send_sample(pack_sample(0, 0, 0, 32'sh0001_0000, 0, 0, ONE_Q30, 0, 0, 0));
        send_sample(pack_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_sample(random_sample(cur_thresh));
        send_sample(random_sample(cur_thresh));
        wait_drain();

        set_config(DEF_THRESH, DEF_GRAVITY, DEF_PERIOD);
        run_random(90);
        wait_drain();

        set_config(32'h7FFF_FFFF, 32'h0000_0000, 32'h00FF_FFFF);
        run_random(90);
        wait_drain();

        // long run with no rest drives position z into saturation
        set_config(32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_FFFF);
        run_random(380);
        wait_drain();

        set_config($urandom_range(0, 32'h0004_0000) | 32'h8000_0000, $urandom, $urandom);
        run_random(100);
        wait_drain();

        set_config(DEF_THRESH, DEF_GRAVITY, 32'h0000_0001);
        cfg_access(1'b1, ADDR_UNMAPPED, $urandom);
        read_all();
        run_random(70);

        i_in_valid <= 1'b0;
        while (results != n_sent) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        if (backlog != 0) begin
            $display("%0d expected results never arrived", backlog);
        end
        $display("run covered %0d imu samples over %0d register settings", n_sent,
                 n_settings + 1);
        $display("%0d results checked, %0d of them at rest", results, rest_results);
        if (mismatches == 0 && backlog == 0) begin
            $display("** inertial_dead_reckoning_zupt: PASSED **");
        end else begin
            $display("** inertial_dead_reckoning_zupt: FAILED **");
        end
        $finish;
    end

endmodule
